// File: src/wpe_pkg.sv
// Shared types and constants for the windowed peak envelope unit.
package wpe_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEN_W = 20;
    localparam int POS_OUT_W = 40;
    localparam int MAG_W = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = 20'd11025;

    localparam int DEF_OFFSET_BITS = 20;
    localparam int DEF_POSITION_BITS = 40;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } wpe_in_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0] peak_position;
        logic [MAG_W-1:0]     peak_magnitude;
    } wpe_out_t;

endpackage

// File: src/windowed_peak_envelope_unit.sv
// Windowed peak envelope follower: per-window peak magnitude and its sample position.
//
// Samples enter on the s_ channel (valid/ready) and are cut into windows of
// window_length samples; the user sets it through cfg_we/cfg_wdata while the block is idle,
// which the block itself does not enforce. A sample with last set closes a partial window
// and restarts positions at zero. One item leaves on the m_ channel per closed window:
// the peak magnitude and the absolute position of its first occurrence (the positive
// peak wins a tie in magnitude). Throughput is one sample per cycle while the output
// does not stall. A sample is held in the input register, where the running
// compare-and-hold updates the trackers, and a result is loaded from there into
// the output register, which drives m_valid.
// When the receiver stalls with a result pending, samples that do not close a
// window still flow; a closing sample waits in the input register, which in
// turn holds s_ready low until the output register frees.
// Reset (synchronous, aresetn low) empties both registers, clears the trackers
// and positions, and sets window_length to 11025.
module windowed_peak_envelope_unit #(
    parameter int OFFSET_BITS   = wpe_pkg::DEF_OFFSET_BITS,
    parameter int POSITION_BITS = wpe_pkg::DEF_POSITION_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [wpe_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  wpe_pkg::wpe_in_t         s_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output wpe_pkg::wpe_out_t        m_item
);
    import wpe_pkg::*;

    localparam int CNT_W = OFFSET_BITS + 1;
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int SUM_W = (POSITION_BITS > CNT_W) ? POSITION_BITS : CNT_W;

    logic [LEN_W-1:0]         window_length_reg;
    logic                     in_valid_reg;
    wpe_in_t                  in_item_reg;
    logic                     m_valid_reg;
    wpe_out_t                 m_item_reg;
    logic [OFFSET_BITS-1:0]   offset_reg, offset_next;
    logic [POSITION_BITS-1:0] window_start_reg, window_start_next;
    logic signed [SAMPLE_W-1:0] high_value_reg, high_value_next;
    logic [OFFSET_BITS-1:0]   high_offset_reg, high_offset_next;
    logic signed [SAMPLE_W-1:0] low_value_reg, low_value_next;
    logic [OFFSET_BITS-1:0]   low_offset_reg, low_offset_next;

    logic                     close;
    logic                     advance;
    logic                     out_load;
    logic [CNT_W-1:0]         count;
    logic [SAMPLE_W:0]        low_mag;
    logic                     take_low;
    logic [OFFSET_BITS-1:0]   peak_offset;
    logic [SUM_W-1:0]         pos_sum;
    logic [SUM_W-1:0]         start_sum;
    logic [POSITION_BITS-1:0] peak_pos;
    logic [POSITION_BITS+POS_OUT_W-1:0] peak_pos_ext;
    wpe_out_t                 result;

    always_comb begin
        high_value_next  = high_value_reg;
        high_offset_next = high_offset_reg;
        low_value_next   = low_value_reg;
        low_offset_next  = low_offset_reg;
        if (in_item_reg.sample > high_value_reg) begin
            high_value_next  = in_item_reg.sample;
            high_offset_next = offset_reg;
        end
        if (in_item_reg.sample < low_value_reg) begin
            low_value_next  = in_item_reg.sample;
            low_offset_next = offset_reg;
        end

        count = {1'b0, offset_reg} + CNT_W'(1);
        close = in_item_reg.last
             || (CMP_W'(count) >= CMP_W'(window_length_reg))
             || (offset_reg == {OFFSET_BITS{1'b1}});

        // The negative peak wins only when its magnitude is strictly larger.
        low_mag     = (SAMPLE_W + 1)'(0) - {low_value_next[SAMPLE_W-1], low_value_next};
        take_low    = low_mag > {1'b0, high_value_next};
        peak_offset = take_low ? low_offset_next : high_offset_next;

        pos_sum      = SUM_W'(window_start_reg) + SUM_W'(peak_offset);
        peak_pos     = pos_sum[POSITION_BITS-1:0];
        peak_pos_ext = {{POS_OUT_W{1'b0}}, peak_pos};
        result.peak_position  = peak_pos_ext[POS_OUT_W-1:0];
        result.peak_magnitude = take_low ? low_mag[MAG_W-1:0] : MAG_W'(high_value_next);

        start_sum = SUM_W'(window_start_reg) + SUM_W'(count);

        offset_next       = offset_reg;
        window_start_next = window_start_reg;
        if (close) begin
            offset_next       = '0;
            high_value_next   = '0;
            high_offset_next  = '0;
            low_value_next    = '0;
            low_offset_next   = '0;
            window_start_next = in_item_reg.last ? '0 : start_sum[POSITION_BITS-1:0];
        end else begin
            offset_next = count[OFFSET_BITS-1:0];
        end
    end

    // A closing sample moves on only when the output register can take its result.
    assign advance  = in_valid_reg && (!close || !m_valid_reg || m_ready);
    assign out_load = advance && close;
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= LEN_RESET;
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            offset_reg        <= '0;
            window_start_reg  <= '0;
            high_value_reg    <= '0;
            high_offset_reg   <= '0;
            low_value_reg     <= '0;
            low_offset_reg    <= '0;
        end else begin
            if (cfg_we) begin
                window_length_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                offset_reg       <= offset_next;
                window_start_reg <= window_start_next;
                high_value_reg   <= high_value_next;
                high_offset_reg  <= high_offset_next;
                low_value_reg    <= low_value_next;
                low_offset_reg   <= low_offset_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (out_load) begin
            m_item_reg <= result;
        end
    end

    // A closing sample must not overwrite a result that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && close && m_valid_reg && !m_ready) |=> in_valid_reg)
        else $error("closing item advanced over a stalled result");

    // End of stream restarts the window and the stream position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.last) |=> (offset_reg == '0 && window_start_reg == '0))
        else $error("last item did not restart the stream");

    // The trackers keep their signs: the high value never negative, the low never positive.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !high_value_reg[SAMPLE_W-1] && (low_value_reg[SAMPLE_W-1] || low_value_reg == '0))
        else $error("peak tracker left its range");

    // The peak magnitude of a result never exceeds the magnitude of the most negative sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_item_reg.peak_magnitude <= 16'd32768))
        else $error("peak magnitude out of range");

endmodule
